FILE: hw/rtl/strict_priority_multi_fifo_defines.svh
// assertion helpers shared by the queue modules
`ifndef STRICT_PRIORITY_MULTI_FIFO_DEFINES_SVH
`define STRICT_PRIORITY_MULTI_FIFO_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define SPMF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define SPMF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/spmf_pkg.sv
package spmf_pkg;

   localparam int LEVELS      = 16;
   localparam int LEVEL_DEPTH = 64;
   localparam int DATA_WIDTH  = 32;

   // widths of the beat fields
   localparam int LVL_W    = 4;
   localparam int OUT_TOT_W = 11;

   // internal widths
   localparam int LIDX_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int PTR_W   = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
   localparam int CNT_W   = $clog2(LEVEL_DEPTH + 1);
   localparam int TOTAL_W = $clog2(LEVELS * LEVEL_DEPTH + 1);
   localparam int ADDR_W  = LIDX_W + PTR_W;
   localparam int WORDS   = LEVELS * LEVEL_DEPTH;

   typedef enum logic {
      MODE_PUSH = 1'b0,
      MODE_POP  = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_FRONT,
      S_RESULT
   } state_type;

   // command broadcast to every level cell
   typedef struct packed {
      logic              push;
      logic              pop;
      logic [LIDX_W-1:0] lvl;
   } cmd_type;

   // information handed from cell to cell along the chain
   typedef struct packed {
      logic              found;
      logic [LIDX_W-1:0] front_lvl;
      logic [PTR_W-1:0]  head;
      logic              full;
      logic [PTR_W-1:0]  tail;
   } link_type;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(LEVEL_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/spmf_cell.sv
`include "strict_priority_multi_fifo_defines.svh"

module spmf_cell
   import spmf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [LIDX_W-1:0] cell_index,
   input  cmd_type           cmd,
   input  link_type          link_in,
   output link_type          link_out
);

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic nonempty;
   logic full;
   logic hit;
   logic sel;
   logic do_push;
   logic do_pop;

   always_comb begin
      nonempty = (count_ff != '0);
      full     = (count_ff == CNT_W'(LEVEL_DEPTH));
      hit      = (cmd.lvl == cell_index);
      // first nonempty cell down the chain owns the front
      sel      = nonempty && !link_in.found;
      do_push  = cmd.push && hit;
      do_pop   = cmd.pop && sel;

      link_out.found     = link_in.found | nonempty;
      link_out.front_lvl = link_in.front_lvl | (sel ? cell_index : '0);
      link_out.head      = link_in.head | (sel ? head_ff : '0);
      link_out.full      = link_in.full | (hit & full);
      link_out.tail      = link_in.tail | (hit ? tail_ff : '0);

      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in  = next_slot(tail_ff);
         count_in = count_ff + 1'b1;
      end else if (do_pop) begin
         head_in  = next_slot(head_ff);
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   `SPMF_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(LEVEL_DEPTH), "level count above depth")
   `SPMF_ASSERT_NOW(a_ptr_match, clock, reset, count_ff == '0 || full, head_ff == tail_ff, "pointers disagree with count")
   `SPMF_ASSERT_NOW(a_push_room, clock, reset, do_push, !full && !do_pop, "push into full level or with pop")

endmodule

FILE: hw/rtl/strict_priority_multi_fifo.sv
// a request beat goes through execute, front read and result; result waits for the output register to be free
// requests are taken one at a time: each goes through idle, execute, front read and response load in turn,
//   set by the word store's single read port: one read for the popped word, then
//   one read for the new front word
// a finished response sits in an output register; the next request is taken meanwhile
// reset clears the per-level pointers, counts and the word total at once
// the word store is not cleared; only written slots ever reach the response
`include "strict_priority_multi_fifo_defines.svh"

module strict_priority_multi_fifo
   import spmf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_mode,
   input  logic [LVL_W-1:0]      req_level,
   input  logic [DATA_WIDTH-1:0] req_data_in,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DATA_WIDTH-1:0] rsp_removed_data,
   output logic                  rsp_front_valid,
   output logic [DATA_WIDTH-1:0] rsp_front_data,
   output logic [LVL_W-1:0]      rsp_front_level,
   output logic [OUT_TOT_W-1:0]  rsp_total_count,
   output logic [1:0]            rsp_status
);

   state_type state_ff, state_in;

   logic                  mode_ff;
   logic [LVL_W-1:0]      lvl_ff;
   logic [DATA_WIDTH-1:0] data_ff;
   status_type            status_ff, status_in;
   logic                  pop_ok_ff, pop_ok_in;
   logic [DATA_WIDTH-1:0] removed_ff;
   logic                  fvalid_ff;
   logic [LIDX_W-1:0]     flvl_ff;
   logic [TOTAL_W-1:0]    total_ff, total_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_removed_ff;
   logic                  rsp_fvalid_ff;
   logic [DATA_WIDTH-1:0] rsp_fdata_ff;
   logic [LVL_W-1:0]      rsp_flvl_ff;
   logic [OUT_TOT_W-1:0]  rsp_total_ff;
   status_type            rsp_status_ff;

   logic [DATA_WIDTH-1:0] mem [WORDS];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic [ADDR_W-1:0]     rd_addr;
   logic [ADDR_W-1:0]     wr_addr;
   logic                  mem_we;

   cmd_type  cmd;
   link_type links [LEVELS+1];

   logic accept_req;
   logic load_rsp;
   logic range_bad;
   logic push_go;
   logic pop_go;

   assign links[0] = '0;

   for (genvar g = 0; g < LEVELS; g++) begin : g_cell
      spmf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (LIDX_W'(g)),
         .cmd        (cmd),
         .link_in    (links[g]),
         .link_out   (links[g+1])
      );
   end

   always_comb begin
      range_bad  = (int'(lvl_ff) >= LEVELS);
      push_go    = (state_ff == S_EXEC) && (mode_ff == MODE_PUSH) && !range_bad
                   && !links[LEVELS].full;
      pop_go     = (state_ff == S_EXEC) && (mode_ff == MODE_POP) && links[LEVELS].found;
      cmd.push   = push_go;
      cmd.pop    = pop_go;
      cmd.lvl    = LIDX_W'(lvl_ff);

      // front slot: popped word in exec, new front word afterwards
      rd_addr    = {links[LEVELS].front_lvl, links[LEVELS].head};
      wr_addr    = {LIDX_W'(lvl_ff), links[LEVELS].tail};
      mem_we     = push_go;

      accept_req = req_valid && (state_ff == S_IDLE);
      load_rsp   = (state_ff == S_RESULT) && (!rsp_valid_ff || rsp_ready);

      state_in   = state_ff;
      status_in  = status_ff;
      pop_ok_in  = pop_ok_ff;
      total_in   = total_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in  = S_FRONT;
            pop_ok_in = pop_go;
            if (mode_ff == MODE_POP) begin
               status_in = pop_go ? STAT_OK : STAT_EMPTY;
            end else if (range_bad) begin
               status_in = STAT_RANGE;
            end else if (links[LEVELS].full) begin
               status_in = STAT_FULL;
            end else begin
               status_in = STAT_OK;
            end
            if (push_go) begin
               total_in = total_ff + 1'b1;
            end else if (pop_go) begin
               total_in = total_ff - 1'b1;
            end
         end
         S_FRONT: begin
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= STAT_OK;
         pop_ok_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
         pop_ok_ff    <= pop_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_req) begin
         mode_ff <= req_mode;
         lvl_ff  <= req_level;
         data_ff <= req_data_in;
      end
      if (state_ff == S_FRONT) begin
         removed_ff <= pop_ok_ff ? rd_data_ff : '0;
         fvalid_ff  <= links[LEVELS].found;
         flvl_ff    <= links[LEVELS].front_lvl;
      end
      if (load_rsp) begin
         rsp_removed_ff <= removed_ff;
         rsp_fvalid_ff  <= fvalid_ff;
         rsp_fdata_ff   <= fvalid_ff ? rd_data_ff : '0;
         rsp_flvl_ff    <= fvalid_ff ? LVL_W'(flvl_ff) : '0;
         rsp_total_ff   <= OUT_TOT_W'(total_ff);
         rsp_status_ff  <= status_ff;
      end
   end

   // word store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= data_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_removed_data = rsp_removed_ff;
   assign rsp_front_valid  = rsp_fvalid_ff;
   assign rsp_front_data   = rsp_fdata_ff;
   assign rsp_front_level  = rsp_flvl_ff;
   assign rsp_total_count  = rsp_total_ff;
   assign rsp_status       = rsp_status_ff;

   `SPMF_ASSERT_NEXT(a_accept_exec, clock, reset, accept_req, state_ff == S_EXEC && !req_ready, "accepted beat did not start work")
   `SPMF_ASSERT_NOW(a_empty_total, clock, reset, total_ff == '0, !links[LEVELS].found, "empty total but a level holds words")
   `SPMF_ASSERT_NEXT(a_pop_total, clock, reset, pop_go, total_ff == $past(total_ff) - 1'b1, "pop did not lower the total")
   `SPMF_ASSERT_NOW(a_write_push, clock, reset, mem_we, state_ff == S_EXEC && mode_ff == MODE_PUSH, "store written outside a push")

endmodule

FILE: tb/strict_priority_multi_fifo_tb.sv
`timescale 1ns / 100ps

module strict_priority_multi_fifo_tb;
   import spmf_pkg::*;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] removed;
      logic                  front_valid;
      logic [DATA_WIDTH-1:0] front_data;
      logic [LVL_W-1:0]      front_level;
      logic [OUT_TOT_W-1:0]  total;
      status_type            status;
   } pq_result_type;

   typedef struct packed {
      mode_type              op;
      logic [LVL_W-1:0]      lvl;
      logic [DATA_WIDTH-1:0] word;
      logic                  typed;
      pq_result_type         want;
   } dir_row_type;

   localparam int RANDOM_OPS = 800;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_mode = MODE_PUSH;
   logic [LVL_W-1:0]      req_level = '0;
   logic [DATA_WIDTH-1:0] req_data_in = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [DATA_WIDTH-1:0] rsp_removed_data;
   logic                  rsp_front_valid;
   logic [DATA_WIDTH-1:0] rsp_front_data;
   logic [LVL_W-1:0]      rsp_front_level;
   logic [OUT_TOT_W-1:0]  rsp_total_count;
   logic [1:0]            rsp_status;

   // shadow copy of the per-level fifos
   logic [DATA_WIDTH-1:0] slots [LEVELS][LEVEL_DEPTH];
   logic [PTR_W-1:0]      rd_ptr [LEVELS];
   logic [PTR_W-1:0]      wr_ptr [LEVELS];
   int                    fill [LEVELS];
   int                    held;

   pq_result_type pending_results [$];
   int            mismatch_count = 0;
   int            burst_left = 0;

   dir_row_type script [20] = '{
      '{MODE_POP,  4'h0, 32'h0000_0000, 1'b1,
        '{32'h0, 1'b0, 32'h0, 4'h0, 11'd0, STAT_EMPTY}},
      '{MODE_PUSH, 4'hf, 32'hffff_ffff, 1'b1,
        '{32'h0, 1'b1, 32'hffff_ffff, 4'hf, 11'd1, STAT_OK}},
      '{MODE_PUSH, 4'h0, 32'h0000_0000, 1'b1,
        '{32'h0, 1'b1, 32'h0, 4'h0, 11'd2, STAT_OK}},
      '{MODE_PUSH, 4'h7, 32'ha5a5_a5a5, 1'b0, '0},
      '{MODE_PUSH, 4'h0, 32'h5a5a_5a5a, 1'b0, '0},
      '{MODE_PUSH, 4'h8, 32'h1234_5678, 1'b0, '0},
      // level and data are don't-care on a pop
      '{MODE_POP,  4'hf, 32'hffff_ffff, 1'b1,
        '{32'h0, 1'b1, 32'h5a5a_5a5a, 4'h0, 11'd4, STAT_OK}},
      '{MODE_POP,  4'h0, 32'h0000_0000, 1'b1,
        '{32'h5a5a_5a5a, 1'b1, 32'ha5a5_a5a5, 4'h7, 11'd3, STAT_OK}},
      '{MODE_POP,  4'h3, 32'h0000_0000, 1'b0, '0},
      '{MODE_PUSH, 4'h3, 32'h0000_0001, 1'b0, '0},
      '{MODE_PUSH, 4'hc, 32'h8000_0000, 1'b0, '0},
      '{MODE_POP,  4'h0, 32'h0000_0000, 1'b0, '0},
      '{MODE_POP,  4'h0, 32'h0000_0000, 1'b0, '0},
      '{MODE_POP,  4'h0, 32'h0000_0000, 1'b0, '0},
      '{MODE_POP,  4'h0, 32'h0000_0000, 1'b1,
        '{32'hffff_ffff, 1'b0, 32'h0, 4'h0, 11'd0, STAT_OK}},
      '{MODE_POP,  4'h9, 32'hdead_beef, 1'b1,
        '{32'h0, 1'b0, 32'h0, 4'h0, 11'd0, STAT_EMPTY}},
      '{MODE_PUSH, 4'h5, 32'hffff_ffff, 1'b0, '0},
      '{MODE_PUSH, 4'h5, 32'h0000_0000, 1'b0, '0},
      '{MODE_POP,  4'h0, 32'h0000_0000, 1'b0, '0},
      '{MODE_POP,  4'h0, 32'h0000_0000, 1'b0, '0}
   };

   strict_priority_multi_fifo dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_level        (req_level),
      .req_data_in      (req_data_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_removed_data (rsp_removed_data),
      .rsp_front_valid  (rsp_front_valid),
      .rsp_front_data   (rsp_front_data),
      .rsp_front_level  (rsp_front_level),
      .rsp_total_count  (rsp_total_count),
      .rsp_status       (rsp_status)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic int first_busy_level();
      int lowest;
      lowest = -1;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (fill[i] != 0) begin
            lowest = i;
         end
      end
      return lowest;
   endfunction

   function automatic pq_result_type apply_queue_op(input mode_type op,
                                                    input logic [LVL_W-1:0] lvl,
                                                    input logic [DATA_WIDTH-1:0] word);
      pq_result_type r;
      int top;
      r = '0;
      r.status = STAT_OK;
      if (op == MODE_PUSH) begin
         if (int'(lvl) >= LEVELS) begin
            r.status = STAT_RANGE;
         end else if (fill[lvl] >= LEVEL_DEPTH) begin
            r.status = STAT_FULL;
         end else begin
            slots[lvl][wr_ptr[lvl]] = word;
            wr_ptr[lvl] = wrap_inc(wr_ptr[lvl]);
            fill[lvl]++;
            held++;
         end
      end else begin
         top = first_busy_level();
         if (top < 0) begin
            r.status = STAT_EMPTY;
         end else begin
            r.removed = slots[top][rd_ptr[top]];
            rd_ptr[top] = wrap_inc(rd_ptr[top]);
            fill[top]--;
            held--;
         end
      end
      top = first_busy_level();
      if (top >= 0) begin
         r.front_valid = 1'b1;
         r.front_data  = slots[top][rd_ptr[top]];
         r.front_level = LVL_W'(top);
      end
      r.total = OUT_TOT_W'(held);
      return r;
   endfunction

   // one request beat; prediction happens on the edge that accepts it
   task automatic send_op(input mode_type op, input logic [LVL_W-1:0] lvl,
                          input logic [DATA_WIDTH-1:0] word, input logic typed,
                          input pq_result_type typed_want);
      pq_result_type pred;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_mode    <= op;
      req_level   <= lvl;
      req_data_in <= word;
      do @(posedge clock); while (!req_ready);
      pred = apply_queue_op(op, lvl, word);
      pending_results.push_back(typed ? typed_want : pred);
   endtask

   // receiver: free-running stretches mixed with on/off stall patterns
   initial begin
      int on_len;
      int off_len;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(20, 60)) @(posedge clock);
         end else begin
            on_len  = $urandom_range(1, 4);
            off_len = $urandom_range(1, 7);
            repeat ($urandom_range(3, 8)) begin
               rsp_ready <= 1'b1;
               repeat (on_len) @(posedge clock);
               rsp_ready <= 1'b0;
               repeat (off_len) @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      pq_result_type got;
      pq_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.removed     = rsp_removed_data;
         got.front_valid = rsp_front_valid;
         got.front_data  = rsp_front_data;
         got.front_level = rsp_front_level;
         got.total       = rsp_total_count;
         got.status      = status_type'(rsp_status);
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("%0t: extra beat removed=%h front=%b/%h/%0d total=%0d st=%0d",
                        $realtime, got.removed, got.front_valid, got.front_data,
                        got.front_level, got.total, got.status);
            end
         end else begin
            want = pending_results.pop_front();
            if (got.removed !== want.removed || got.front_valid !== want.front_valid ||
                got.front_data !== want.front_data || got.front_level !== want.front_level ||
                got.total !== want.total || got.status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: mismatch", $realtime);
                  $display("   expected removed=%h front=%b/%h/%0d total=%0d st=%0d",
                           want.removed, want.front_valid, want.front_data,
                           want.front_level, want.total, want.status);
                  $display("   actual   removed=%h front=%b/%h/%0d total=%0d st=%0d",
                           got.removed, got.front_valid, got.front_data,
                           got.front_level, got.total, got.status);
               end
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      mode_type              op;
      logic [LVL_W-1:0]      lvl;
      logic [DATA_WIDTH-1:0] word;
      int sent;
      int seg_kind;
      int seg_len;
      int hot_lvl;
      int alt_lvl;
      int push_pct;
      int spin;

      for (int i = 0; i < LEVELS; i++) begin
         rd_ptr[i] = '0;
         wr_ptr[i] = '0;
         fill[i]   = 0;
      end
      held = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         send_op(script[i].op, script[i].lvl, script[i].word, script[i].typed,
                 script[i].want);
      end

      // segments: flood one level, drain, wide mix, two-level mix; the first one floods
      sent     = 0;
      seg_kind = 0;
      while (sent < RANDOM_OPS) begin
         hot_lvl = $urandom_range(0, LEVELS - 1);
         alt_lvl = $urandom_range(0, LEVELS - 1);
         case (seg_kind)
            0: begin
               seg_len  = $urandom_range(75, 110);
               push_pct = 95;
            end
            1: begin
               seg_len  = $urandom_range(40, 120);
               push_pct = 15;
            end
            2: begin
               seg_len  = $urandom_range(40, 100);
               push_pct = 55;
            end
            default: begin
               seg_len  = $urandom_range(40, 100);
               push_pct = 60;
            end
         endcase
         for (int k = 0; k < seg_len && sent < RANDOM_OPS; k++) begin
            op = ($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP;
            case (seg_kind)
               0: lvl = ($urandom_range(0, 9) == 0) ? LVL_W'($urandom) : LVL_W'(hot_lvl);
               3: lvl = $urandom_range(0, 1) ? LVL_W'(hot_lvl) : LVL_W'(alt_lvl);
               default: lvl = LVL_W'($urandom);
            endcase
            case ($urandom_range(0, 15))
               0: word = '0;
               1: word = '1;
               default: word = DATA_WIDTH'($urandom);
            endcase
            send_op(op, lvl, word, 1'b0, '0);
            sent++;
         end
         seg_kind = $urandom_range(0, 3);
      end
      req_valid <= 1'b0;

      spin = 0;
      while (pending_results.size() != 0 && spin < 5000) begin
         @(posedge clock);
         spin++;
      end
      repeat (16) @(posedge clock);
      mismatch_count += pending_results.size();

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
